[rtl/ecgbd_pkg.sv]
// Package with shared constants and types of the ECG beat detector.
`timescale 1ns / 1ps

package ecgbd_pkg;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 19;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASELINE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REFRACTORY  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_RATE = 3'd4;

    // Register widths and reset values.
    localparam int BASE_BITS   = 10;
    localparam int ALPHA_BITS  = 16;
    localparam int SLOPE_BITS  = 19;
    localparam int OUT16_BITS  = 16;

    localparam logic [BASE_BITS-1:0]  BASE_RESET  = 10'd475;
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd7313;
    localparam logic [SLOPE_BITS-1:0] THR_RESET   = 19'd1200;
    localparam logic [OUT16_BITS-1:0] REFR_RESET  = 16'd100;
    localparam logic [OUT16_BITS-1:0] RATE_RESET  = 16'd500;

    localparam logic [SLOPE_BITS-1:0] SLOPE_MAX = 19'h7FFFF;
    localparam logic [OUT16_BITS-1:0] OUT16_MAX = 16'hFFFF;

    // 60 * sample_rate_hz fits in 22 bits.
    localparam int RATE_NUM_BITS = 22;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

[rtl/ecgbd_if.sv]
// Handshake interfaces of the ECG beat detector: sample input, result output, configuration.
`timescale 1ns / 1ps

interface ecgbd_in_if #(
    parameter int SAMPLE_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ecgbd_out_if import ecgbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [SLOPE_BITS-1:0] slope_magnitude;
    logic                  beat;
    logic [OUT16_BITS-1:0] beat_interval;
    logic [OUT16_BITS-1:0] rate_bpm;

    modport source (output valid, output slope_magnitude, output beat,
                    output beat_interval, output rate_bpm, input ready);
    modport sink   (input valid, input slope_magnitude, input beat,
                    input beat_interval, input rate_bpm, output ready);
endinterface

interface ecgbd_cfg_if import ecgbd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ecgbd_mul.sv]
// Serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module ecgbd_mul import ecgbd_pkg::*; #(
    parameter int A_W = 20,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_product,
    output t_unit_sts          o_sts
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_prod;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [A_W:0]       n_sum;

    // Add the multiplicand to the upper half when the current multiplier bit is set.
    assign n_sum = {1'b0, r_prod[A_W+B_W-1:B_W]} + {1'b0, (r_prod[0] ? r_a : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= {n_sum, r_prod[B_W-1:1]};
        end
    end

    assign o_product = r_prod;
    assign o_sts     = '{busy: r_busy, done: r_done};

endmodule

[rtl/ecgbd_div.sv]
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ecgbd_div import ecgbd_pkg::*; #(
    parameter int N_W = 22,
    parameter int D_W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [N_W-1:0] o_quotient,
    output t_unit_sts      o_sts
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_num;
    logic [D_W-1:0]   r_den;
    logic [D_W-1:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [D_W:0]     n_trial;
    logic [D_W:0]     n_diff;
    logic             n_ge;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign n_trial = {r_rem, r_num[N_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[D_W-1:0] : n_trial[D_W-1:0];
            r_num <= {r_num[N_W-2:0], n_ge};
        end
    end

    assign o_quotient = r_num;
    assign o_sts      = '{busy: r_busy, done: r_done};

endmodule

[rtl/ecg_beat_detector.sv]
// Top level of the ECG beat detector: baseline, energy, low-pass, slope, beat and rate logic.
//
//  Channel  Direction  Payload                                        Transfer when
//  i_in     sink       sample                                         valid && ready
//  o_out    source     slope_magnitude, beat, beat_interval, rate_bpm valid && ready
//  i_cfg    sink       index, data                                    valid && ready
//
// After its transfer a sample passes through the squaring, filter, slope and decision
// states, and through the serial rate division when it flags a beat, before its result
// is loaded in the last state; the next sample is taken only once that result has been
// loaded, so the block does not take a new sample before it is through with the last.
// The work is done by the serial squaring multiplier (one bit of the difference per
// cycle), the serial filter multiplier (one bit of alpha per cycle) and the restoring
// divider (one quotient bit per cycle). One sample is worked on at a time.
// Reset is synchronous and active low; it restores the register defaults and clears
// the filter, the sample counter and the held interval and rate.
// A stalled output holds its result; the next sample may be taken meanwhile, and it
// waits in the last state until the output register is free.
`timescale 1ns / 1ps

module ecg_beat_detector import ecgbd_pkg::*; #(
    parameter int SAMPLE_BITS     = 10,
    parameter int COUNT_BITS      = 16,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ecgbd_in_if.sink     i_in,
    ecgbd_out_if.source  o_out,
    ecgbd_cfg_if.sink    i_cfg
);

    // Width of the baseline-corrected magnitude, the filter integer part and the
    // whole filter state with its fraction bits.
    localparam int DW  = (SAMPLE_BITS > BASE_BITS) ? SAMPLE_BITS : BASE_BITS;
    localparam int IW  = 2 * DW;
    localparam int F   = ALPHA_FRAC_BITS;
    localparam int YW  = IW + F;
    localparam int AW  = (F > ALPHA_BITS) ? F : ALPHA_BITS;
    localparam int CW  = (COUNT_BITS > OUT16_BITS) ? COUNT_BITS : OUT16_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQ     = 3'd1;
    localparam logic [2:0] S_FILT   = 3'd2;
    localparam logic [2:0] S_SLOPE  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // Configuration registers.
    logic [BASE_BITS-1:0]  r_base;
    logic [ALPHA_BITS-1:0] r_alpha;
    logic [SLOPE_BITS-1:0] r_thr;
    logic [OUT16_BITS-1:0] r_refr;
    logic [OUT16_BITS-1:0] r_rate_hz;

    // Control and detector state.
    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [YW-1:0]         r_y;
    logic [IW-1:0]         r_old_i;
    logic                  r_up;
    logic [SLOPE_BITS-1:0] r_slope;
    logic [COUNT_BITS-1:0] r_count;
    logic [OUT16_BITS-1:0] r_held_iv;
    logic [OUT16_BITS-1:0] r_held_rate;
    logic                  r_beat;

    // Output register.
    logic                  r_out_valid;
    logic [SLOPE_BITS-1:0] r_o_slope;
    logic                  r_o_beat;
    logic [OUT16_BITS-1:0] r_o_iv;
    logic [OUT16_BITS-1:0] r_o_rate;

    // Arithmetic signals.
    logic [DW-1:0]            s_ext;
    logic [DW-1:0]            b_ext;
    logic [DW-1:0]            diff_abs;
    logic [AW-1:0]            alpha_ext;
    logic [F-1:0]             alpha_f;
    logic [YW-1:0]            energy;
    logic                     energy_ge;
    logic [YW-1:0]            mag;
    logic [YW-1:0]            step;
    logic [YW-1:0]            new_y;
    logic [IW-1:0]            slope_full;
    logic [CW-1:0]            count_ext;
    logic                     beat_now;
    logic [RATE_NUM_BITS-1:0] rate_num;

    logic                     in_xfer;
    logic                     out_load;
    logic                     sq_start;
    logic                     filt_start;
    logic                     div_start;
    logic [IW-1:0]            sq_prod;
    logic [YW+F-1:0]          filt_prod;
    logic [RATE_NUM_BITS-1:0] div_q;
    t_unit_sts                sq_sts;
    t_unit_sts                filt_sts;
    t_unit_sts                div_sts;

    // Configuration writes are always taken; an unknown index is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= BASE_RESET;
            r_alpha   <= ALPHA_RESET;
            r_thr     <= THR_RESET;
            r_refr    <= REFR_RESET;
            r_rate_hz <= RATE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BASELINE:    r_base    <= i_cfg.data[BASE_BITS-1:0];
                CFG_ALPHA:       r_alpha   <= i_cfg.data[ALPHA_BITS-1:0];
                CFG_THRESHOLD:   r_thr     <= i_cfg.data[SLOPE_BITS-1:0];
                CFG_REFRACTORY:  r_refr    <= i_cfg.data[OUT16_BITS-1:0];
                CFG_SAMPLE_RATE: r_rate_hz <= i_cfg.data[OUT16_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A sample is taken only when no other sample is in flight.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    // Baseline removal: the magnitude of the difference is all that the square needs.
    assign s_ext    = DW'(i_in.sample);
    assign b_ext    = DW'(r_base);
    assign diff_abs = (s_ext >= b_ext) ? (s_ext - b_ext) : (b_ext - s_ext);

    assign sq_start = in_xfer;

    ecgbd_mul #(
        .A_W (DW),
        .B_W (DW)
    ) u_sq_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_a       (diff_abs),
        .i_b       (diff_abs),
        .o_product (sq_prod),
        .o_sts     (sq_sts)
    );

    // The energy takes the filter's fixed-point format. The filter step is taken on
    // the magnitude of the error, and its direction is kept aside.
    assign alpha_ext = AW'(r_alpha);
    assign alpha_f   = alpha_ext[F-1:0];
    assign energy    = {sq_prod, {F{1'b0}}};
    assign energy_ge = energy >= r_y;
    assign mag       = energy_ge ? (energy - r_y) : (r_y - energy);

    assign filt_start = (r_state == S_SQ) && sq_sts.done;

    ecgbd_mul #(
        .A_W (YW),
        .B_W (F)
    ) u_filt_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (filt_start),
        .i_a       (mag),
        .i_b       (alpha_f),
        .o_product (filt_prod),
        .o_sts     (filt_sts)
    );

    // Dropping the low fraction bits of the product floors the step.
    assign step  = filt_prod[YW+F-1:F];
    assign new_y = r_up ? (r_y + step) : (r_y - step);

    assign slope_full = (r_y[YW-1:F] >= r_old_i) ? (r_y[YW-1:F] - r_old_i)
                                                 : (r_old_i - r_y[YW-1:F]);

    // Beat decision on the already incremented counter.
    assign count_ext = CW'(r_count);
    assign beat_now  = (count_ext >= CW'(r_refr)) && (r_slope > r_thr);

    // 60 * rate = 64 * rate - 4 * rate.
    assign rate_num  = ({r_rate_hz, 6'd0} - {4'd0, r_rate_hz, 2'd0});
    assign div_start = (r_state == S_DECIDE) && beat_now;

    ecgbd_div #(
        .N_W (RATE_NUM_BITS),
        .D_W (COUNT_BITS)
    ) u_rate_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_num      (rate_num),
        .i_den      (r_count),
        .o_quotient (div_q),
        .o_sts      (div_sts)
    );

    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_xfer) n_state = S_SQ;
            S_SQ:     if (sq_sts.done) n_state = S_FILT;
            S_FILT:   if (filt_sts.done) n_state = S_SLOPE;
            S_SLOPE:  n_state = S_DECIDE;
            S_DECIDE: n_state = beat_now ? S_DIV : S_OUT;
            S_DIV:    if (div_sts.done) n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_y         <= '0;
            r_count     <= '0;
            r_held_iv   <= '0;
            r_held_rate <= '0;
            r_beat      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (filt_start) begin
                r_up <= energy_ge;
            end

            // Filter update; the old integer part is kept for the slope.
            if ((r_state == S_FILT) && filt_sts.done) begin
                r_y     <= new_y;
                r_old_i <= r_y[YW-1:F];
            end

            // Saturating sample counter and saturated slope.
            if (r_state == S_SLOPE) begin
                if (r_count != {COUNT_BITS{1'b1}}) begin
                    r_count <= r_count + 1'b1;
                end
                if (slope_full > IW'(SLOPE_MAX)) begin
                    r_slope <= SLOPE_MAX;
                end else begin
                    r_slope <= slope_full[SLOPE_BITS-1:0];
                end
            end

            // A beat latches the interval, restarts the counter and starts the divider.
            if (r_state == S_DECIDE) begin
                r_beat <= beat_now;
                if (beat_now) begin
                    if (count_ext > CW'(OUT16_MAX)) begin
                        r_held_iv <= OUT16_MAX;
                    end else begin
                        r_held_iv <= count_ext[OUT16_BITS-1:0];
                    end
                    r_count <= '0;
                end
            end

            if ((r_state == S_DIV) && div_sts.done) begin
                if (div_q > RATE_NUM_BITS'(OUT16_MAX)) begin
                    r_held_rate <= OUT16_MAX;
                end else begin
                    r_held_rate <= div_q[OUT16_BITS-1:0];
                end
            end

            // The output register is refilled from the last state, or frees on a transfer.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_slope <= r_slope;
            r_o_beat  <= r_beat;
            r_o_iv    <= r_held_iv;
            r_o_rate  <= r_held_rate;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.slope_magnitude = r_o_slope;
    assign o_out.beat            = r_o_beat;
    assign o_out.beat_interval   = r_o_iv;
    assign o_out.rate_bpm        = r_o_rate;

    // No arithmetic unit may still be running while a new sample can be taken.
    a_units_quiet_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!sq_sts.busy && !filt_sts.busy && !div_sts.busy))
        else $error("arithmetic unit busy while idle");

    // The rate division never starts on a zero interval.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_count != '0))
        else $error("rate division started with zero interval");

    // After a beat the sample counter restarts from zero.
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DECIDE) && beat_now) |=> (r_count == '0))
        else $error("sample counter not cleared on beat");

    // A reported beat always carries a nonzero interval.
    a_beat_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.beat) |-> (o_out.beat_interval != '0))
        else $error("beat reported with zero interval");

endmodule

[tb/ecg_beat_detector_checker.sv]
// Checker that predicts every result of the ECG beat detector and compares it with the output.
`timescale 1ns / 1ps

module ecg_beat_detector_checker import ecgbd_pkg::*; #(
    parameter int SAMPLE_BITS     = 10,
    parameter int COUNT_BITS      = 16,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ecgbd_in_if  i_in_mon,
    ecgbd_out_if i_out_mon,
    ecgbd_cfg_if i_cfg_mon,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam logic [63:0] SAMPLE_MASK = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam logic [63:0] FRAC_MASK   = (64'd1 << ALPHA_FRAC_BITS) - 64'd1;
    localparam logic [63:0] COUNT_MAX   = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic [SLOPE_BITS-1:0] slope;
        logic                  beat;
        logic [OUT16_BITS-1:0] interval;
        logic [OUT16_BITS-1:0] bpm;
    } t_beat_report;

    t_beat_report expected_reports[$];

    // Shadow of the configuration registers.
    logic [BASE_BITS-1:0]  baseline;
    logic [ALPHA_BITS-1:0] alpha;
    logic [SLOPE_BITS-1:0] threshold;
    logic [OUT16_BITS-1:0] refractory;
    logic [OUT16_BITS-1:0] rate_hz;

    // Detector state: low-pass value with fraction bits, counter and held outputs.
    logic [63:0]           energy_lp;
    logic [63:0]           since_beat;
    logic [OUT16_BITS-1:0] held_interval;
    logic [OUT16_BITS-1:0] held_bpm;

    int results_seen;

    // floor(mag * coef / 2^F), split so the products stay inside 64 bits.
    function automatic logic [63:0] scale_step(input logic [63:0] mag, input logic [63:0] coef);
        return (mag >> ALPHA_FRAC_BITS) * coef + (((mag & FRAC_MASK) * coef) >> ALPHA_FRAC_BITS);
    endfunction

    function automatic t_beat_report step_detector(input logic [63:0] raw);
        logic [63:0]  s;
        logic [63:0]  delta;
        logic [63:0]  energy;
        logic [63:0]  coef;
        logic [63:0]  old_int;
        logic [63:0]  new_int;
        logic [63:0]  slope;
        logic [63:0]  ratio;
        t_beat_report rep;
        s      = raw & SAMPLE_MASK;
        delta  = (s >= baseline) ? s - baseline : baseline - s;
        energy = (delta * delta) << ALPHA_FRAC_BITS;
        coef   = alpha & FRAC_MASK;

        // The filter moves toward the energy and never past it.
        old_int = energy_lp >> ALPHA_FRAC_BITS;
        if (energy >= energy_lp) begin
            energy_lp = energy_lp + scale_step(energy - energy_lp, coef);
        end else begin
            energy_lp = energy_lp - scale_step(energy_lp - energy, coef);
        end
        new_int = energy_lp >> ALPHA_FRAC_BITS;
        slope   = (new_int >= old_int) ? new_int - old_int : old_int - new_int;
        if (slope > SLOPE_MAX) begin
            slope = SLOPE_MAX;
        end

        if (since_beat < COUNT_MAX) begin
            since_beat = since_beat + 64'd1;
        end

        rep.beat = 1'b0;
        if (since_beat >= refractory && slope > threshold) begin
            rep.beat      = 1'b1;
            held_interval = (since_beat > OUT16_MAX) ? OUT16_MAX : since_beat[OUT16_BITS-1:0];
            ratio         = 64'd0;
            if (since_beat != 64'd0) begin
                ratio = (64'd60 * rate_hz) / since_beat;
            end
            held_bpm   = (ratio > OUT16_MAX) ? OUT16_MAX : ratio[OUT16_BITS-1:0];
            since_beat = 64'd0;
        end

        rep.slope    = slope[SLOPE_BITS-1:0];
        rep.interval = held_interval;
        rep.bpm      = held_bpm;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_beat_report want;
        t_beat_report got;
        if (!i_rst_n) begin
            baseline      = BASE_RESET;
            alpha         = ALPHA_RESET;
            threshold     = THR_RESET;
            refractory    = REFR_RESET;
            rate_hz       = RATE_RESET;
            energy_lp     = 64'd0;
            since_beat    = 64'd0;
            held_interval = '0;
            held_bpm      = '0;
            results_seen  = 0;
            o_mismatches  = 0;
            expected_reports.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    CFG_BASELINE:    baseline   = i_cfg_mon.data[BASE_BITS-1:0];
                    CFG_ALPHA:       alpha      = i_cfg_mon.data[ALPHA_BITS-1:0];
                    CFG_THRESHOLD:   threshold  = i_cfg_mon.data[SLOPE_BITS-1:0];
                    CFG_REFRACTORY:  refractory = i_cfg_mon.data[OUT16_BITS-1:0];
                    CFG_SAMPLE_RATE: rate_hz    = i_cfg_mon.data[OUT16_BITS-1:0];
                    default: ;
                endcase
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                got.slope    = i_out_mon.slope_magnitude;
                got.beat     = i_out_mon.beat;
                got.interval = i_out_mon.beat_interval;
                got.bpm      = i_out_mon.rate_bpm;
                if (expected_reports.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("result %0d arrived with nothing expected: slope %0d beat %0d",
                                 results_seen, got.slope, got.beat);
                    end
                    o_mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.slope !== want.slope || got.beat !== want.beat ||
                        got.interval !== want.interval || got.bpm !== want.bpm) begin
                        if (o_mismatches < 10) begin
                            $display("result %0d: expected slope %0d beat %0d interval %0d bpm %0d",
                                     results_seen, want.slope, want.beat, want.interval, want.bpm);
                            $display("result %0d: actual   slope %0d beat %0d interval %0d bpm %0d",
                                     results_seen, got.slope, got.beat, got.interval, got.bpm);
                        end
                        o_mismatches++;
                    end
                end
                results_seen++;
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_reports.push_back(step_detector(64'(i_in_mon.sample)));
            end
        end
        o_outstanding = expected_reports.size();
    end

endmodule

[tb/ecg_beat_detector_tb.sv]
// Testbench top of the ECG beat detector: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module ecg_beat_detector_tb;
    import ecgbd_pkg::*;

    // The run limit lies well beyond the slowest correct run.
    localparam int TIMEOUT_NS   = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASES       = 8;
    localparam int ECG_ITEMS    = 90;

    // Directed samples: both rail values, the default baseline and its neighbors,
    // alternating bit patterns and large swings in both directions.
    localparam logic [9:0] EDGE_SAMPLES [20] = '{
        10'd0,   10'd1023, 10'd1023, 10'd0,   10'd475,  10'd475,  10'd476,
        10'd474, 10'h155,  10'h2AA,  10'h155, 10'h2AA,  10'd1023, 10'd0,
        10'd512, 10'd511,  10'd1,    10'd1022, 10'd475, 10'd1023
    };

    logic i_clk;
    logic i_rst_n;

    // While this is set neither side idles, so the block runs at its full rate.
    logic steady;

    // Rough copies of two registers, used only to shape the synthetic ECG.
    int base_level;
    int refr_level;

    int mismatches;
    int outstanding;

    ecgbd_in_if #(.SAMPLE_BITS(10)) in_ch ();
    ecgbd_out_if                    out_ch ();
    ecgbd_cfg_if                    cfg_ch ();

    ecg_beat_detector uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ecg_beat_detector_checker beat_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .i_cfg_mon     (cfg_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #1 i_clk = ~i_clk;

    // The result side stalls at random, with ready low about 7 percent of the time, except in the
    // steady stretch. Ready changes only at the falling edge.
    always @(negedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= 7);
    end

    // Clamps a synthetic level into the ADC range.
    function automatic logic [9:0] clip_sample(input int level);
        if (level < 0) begin
            return 10'd0;
        end
        if (level > 1023) begin
            return 10'd1023;
        end
        return 10'(level);
    endfunction

    // Offers one sample and returns at the falling edge after its transfer. Valid is
    // left high so that back-to-back samples never lower and raise it in one step.
    task automatic send_sample(input logic [9:0] value);
        while (!steady && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes one register and returns at a fresh falling edge with valid low again.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_BASELINE) begin
            base_level = value[BASE_BITS-1:0];
        end
        if (idx == CFG_REFRACTORY) begin
            refr_level = value[OUT16_BITS-1:0];
        end
    endtask

    // Synthetic ECG: a flat line with small jitter around the baseline and a short
    // QRS-like spike once per beat period. The period is chosen a little above the
    // refractory count, taken as at most 150, so that most spikes can flag a beat. One
    // sample in ten is plain noise, which breaks up the rhythm now and then.
    task automatic run_ecg(input int count);
        int k;
        int pos;
        int period;
        int amp;
        int lo;
        logic [9:0] value;
        lo     = ((refr_level > 150) ? 150 : refr_level) + 2;
        pos    = 0;
        period = $urandom_range(lo + 40, lo);
        amp    = $urandom_range(1023, 100);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 10) begin
                value = 10'($urandom_range(1023));
            end else if (pos < 3) begin
                value = $urandom_range(1) ? clip_sample(base_level + amp)
                                          : clip_sample(base_level - amp);
            end else begin
                value = clip_sample(base_level + $urandom_range(16) - 8);
            end
            send_sample(value);
            pos++;
            if (pos >= period) begin
                pos    = 0;
                period = $urandom_range(lo + 40, lo);
                amp    = $urandom_range(1023, 100);
            end
        end
    endtask

    // Run limit, independent of the stimulus.
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int phase;
        int k;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        steady       = 1'b0;
        base_level   = BASE_RESET;
        refr_level   = REFR_RESET;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;

        // Synchronous reset, released at a falling edge.
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (phase = 0; phase < PHASES; phase++) begin
            steady = (phase == 6);

            // The block is idle here: every sample so far has produced its result.
            case (phase)
                0: begin
                    // Reset defaults. The first beat of this phase counts its interval
                    // from reset, directed samples included.
                end
                1: begin
                    // Upper data bits set so that the register masks are exercised:
                    // baseline ends up 0 and alpha at its maximum. With no threshold
                    // and no refractory time a beat follows nearly every sample, at an
                    // interval of one and a clamped rate. Full swings saturate the slope.
                    write_reg(CFG_BASELINE, 19'h7FC00);
                    write_reg(CFG_ALPHA, 19'h7FFFF);
                    write_reg(CFG_THRESHOLD, 19'd0);
                    write_reg(CFG_REFRACTORY, 19'd0);
                    write_reg(CFG_SAMPLE_RATE, 19'd65535);
                end
                2: begin
                    // Alpha masks to zero: the filter freezes, the slope stays zero and
                    // no beat can exceed even a zero threshold. Writes beyond the
                    // register list must change nothing.
                    write_reg(CFG_ALPHA, 19'h70000);
                    write_reg(CFG_REFRACTORY, 19'd1);
                    write_reg(3'd5, CFG_DATA_BITS'($urandom_range(19'h7FFFF)));
                    write_reg(3'd6, CFG_DATA_BITS'($urandom_range(19'h7FFFF)));
                    write_reg(3'd7, CFG_DATA_BITS'($urandom_range(19'h7FFFF)));
                end
                3: begin
                    // A zero sample rate gives a rate of zero on every beat.
                    write_reg(CFG_BASELINE, 19'd1023);
                    write_reg(CFG_ALPHA, 19'd30000);
                    write_reg(CFG_THRESHOLD, 19'd50);
                    write_reg(CFG_REFRACTORY, 19'd2);
                    write_reg(CFG_SAMPLE_RATE, 19'd0);
                end
                4: begin
                    // Largest threshold and refractory count: no beat at all.
                    write_reg(CFG_THRESHOLD, 19'h7FFFF);
                    write_reg(CFG_REFRACTORY, 19'd65535);
                    write_reg(CFG_SAMPLE_RATE, 19'd1);
                end
                6: begin
                    // Defaults with a short refractory time, run without any idling.
                    write_reg(CFG_BASELINE, 19'(BASE_RESET));
                    write_reg(CFG_ALPHA, 19'(ALPHA_RESET));
                    write_reg(CFG_THRESHOLD, 19'(THR_RESET));
                    write_reg(CFG_REFRACTORY, 19'd30);
                    write_reg(CFG_SAMPLE_RATE, 19'(RATE_RESET));
                end
                default: begin
                    // Random settings, raw data bits above the register widths included.
                    write_reg(CFG_BASELINE, CFG_DATA_BITS'($urandom_range(19'h7FFFF)));
                    write_reg(CFG_ALPHA, CFG_DATA_BITS'($urandom_range(19'h7FFFF)));
                    write_reg(CFG_THRESHOLD, CFG_DATA_BITS'($urandom_range(30000)));
                    write_reg(CFG_REFRACTORY, CFG_DATA_BITS'($urandom_range(60)));
                    write_reg(CFG_SAMPLE_RATE, CFG_DATA_BITS'($urandom_range(65535)));
                    write_reg(3'($urandom_range(7, 5)), CFG_DATA_BITS'($urandom_range(19'h7FFFF)));
                end
            endcase

            if (phase == 0) begin
                for (k = 0; k < 20; k++) begin
                    send_sample(EDGE_SAMPLES[k]);
                end
            end
            run_ecg(ECG_ITEMS);

            // Close the phase: stop offering samples and let every result drain
            // before the next register write.
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
            while (outstanding != 0) @(negedge i_clk);
        end

        // The drain wait catches any stray transfer after the last expected result.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ecgbd_pkg.sv
rtl/ecgbd_if.sv
rtl/ecgbd_mul.sv
rtl/ecgbd_div.sv
rtl/ecg_beat_detector.sv
tb/ecg_beat_detector_checker.sv
tb/ecg_beat_detector_tb.sv
